/* hw/rtl/pes_pkg.sv */
// ----------------------------------------------------------------------------
// pes_pkg: shared types and constants for the product-except-self core
// Item structs for both channels and default sizing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pes_pkg;

	localparam int DATA_W      = 32;
	localparam int MAX_LEN_DEF = 64;

	typedef struct packed {
		logic signed [DATA_W-1:0] element;
		logic                     is_last;
	} pes_req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] product;
		logic                     last_result;
		logic                     truncated;
	} pes_rsp_t;

endpackage

/* hw/rtl/pes_mul.sv */
// ----------------------------------------------------------------------------
// pes_mul: shared wrapping multiplier
// Low half of a 32x32 product, registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pes_mul (
	input  logic                       clk,
	input  logic [pes_pkg::DATA_W-1:0] a,
	input  logic [pes_pkg::DATA_W-1:0] b,
	output logic [pes_pkg::DATA_W-1:0] p_q
);

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

/* hw/rtl/pes_mem.sv */
// ----------------------------------------------------------------------------
// pes_mem: vector store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pes_mem #(
	parameter int DEPTH = pes_pkg::MAX_LEN_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [AW-1:0]              wr_addr,
	input  logic [pes_pkg::DATA_W-1:0] wr_data,
	input  logic [AW-1:0]              rd_addr,
	output logic [pes_pkg::DATA_W-1:0] rd_q
);

	logic [pes_pkg::DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
	end

endmodule

/* hw/rtl/product_except_self_core.sv */
// ----------------------------------------------------------------------------
// product_except_self_core: product of a vector except each element
// Loads a vector, then emits for each position the product of all others.
// ----------------------------------------------------------------------------
//  channel | dir | handshake              | item
//  req     | in  | req_valid / req_stall  | element, is_last
//  rsp     | out | rsp_valid / rsp_stall  | product, last_result, truncated
//
//  Load: each element goes to the store, then the running product is updated
//  through the shared multiplier. After the last element, the backward pass
//  runs BRD, then BM1, BM2, BM3 per stored element (two multiplies share one
//  unit). After ERD and EFST results leave at 1 per cycle unless stalled.
//  req_stall is high for the whole backward and emit phase.
//  Reset: asynchronous, clears the run; stores need no clearing.
//  rsp stalls hold the result register and the read pointer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module product_except_self_core #(
	parameter int MAX_LEN = pes_pkg::MAX_LEN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  pes_pkg::pes_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output pes_pkg::pes_rsp_t rsp
);

	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CW = $clog2(MAX_LEN + 1);
	localparam int DW = pes_pkg::DATA_W;

	localparam logic [3:0] ST_LOAD = 4'd0;
	localparam logic [3:0] ST_ACC  = 4'd1;
	localparam logic [3:0] ST_BRD  = 4'd2;
	localparam logic [3:0] ST_BM1  = 4'd3;
	localparam logic [3:0] ST_BM2  = 4'd4;
	localparam logic [3:0] ST_BM3  = 4'd5;
	localparam logic [3:0] ST_ERD  = 4'd6;
	localparam logic [3:0] ST_EFST = 4'd7;
	localparam logic [3:0] ST_EOUT = 4'd8;

	logic [3:0]        state_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     idx_q;
	logic [DW-1:0]     run_q;
	logic [DW-1:0]     suffix_q;
	logic              ovf_q;
	logic              out_valid_q;
	pes_pkg::pes_rsp_t out_q;

	logic          req_acc;
	logic          rsp_acc;
	logic          has_room;
	logic [CW-1:0] idx_nxt;
	logic [CW-1:0] rd_idx;
	logic          is_end;

	logic [DW-1:0] mul_a;
	logic [DW-1:0] mul_b;
	logic [DW-1:0] mul_p;

	logic          elem_we;
	logic [DW-1:0] elem_rd;
	logic          part_we;
	logic [AW-1:0] part_wa;
	logic [DW-1:0] part_wd;
	logic [DW-1:0] part_rd;

	assign req_stall = (state_q != ST_LOAD);
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	assign req_acc  = req_valid && !req_stall;
	assign rsp_acc  = out_valid_q && !rsp_stall;
	assign has_room = (count_q < CW'(MAX_LEN));
	assign idx_nxt  = idx_q + CW'(1);
	assign is_end   = (idx_nxt == count_q);

	always_comb begin
		mul_a = run_q;
		mul_b = req.element;
		case (state_q)
			ST_BM1: begin
				mul_a = part_rd;
				mul_b = suffix_q;
			end
			ST_BM2: begin
				mul_a = suffix_q;
				mul_b = elem_rd;
			end
			default: begin
				mul_a = run_q;
				mul_b = req.element;
			end
		endcase
	end

	always_comb begin
		rd_idx = idx_q;
		case (state_q)
			ST_BM3:  rd_idx = idx_q - CW'(1);
			ST_EFST: rd_idx = idx_nxt;
			ST_EOUT: rd_idx = rsp_acc ? idx_nxt : idx_q;
			default: rd_idx = idx_q;
		endcase
	end

	assign elem_we = (state_q == ST_LOAD) && req_acc && has_room;
	assign part_we = elem_we || (state_q == ST_BM2);
	assign part_wa = (state_q == ST_BM2) ? idx_q[AW-1:0] : count_q[AW-1:0];
	assign part_wd = (state_q == ST_BM2) ? mul_p : run_q;

	pes_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	pes_mem #(
		.DEPTH (MAX_LEN),
		.AW    (AW)
	) u_elem_mem (
		.clk     (clk),
		.wr_en   (elem_we),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (req.element),
		.rd_addr (rd_idx[AW-1:0]),
		.rd_q    (elem_rd)
	);

	pes_mem #(
		.DEPTH (MAX_LEN),
		.AW    (AW)
	) u_part_mem (
		.clk     (clk),
		.wr_en   (part_we),
		.wr_addr (part_wa),
		.wr_data (part_wd),
		.rd_addr (rd_idx[AW-1:0]),
		.rd_q    (part_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			count_q     <= '0;
			idx_q       <= '0;
			run_q       <= DW'(1);
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (req_acc) begin
						if (has_room) begin
							count_q <= count_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (req.is_last) begin
							idx_q   <= has_room ? count_q : count_q - CW'(1);
							state_q <= ST_BRD;
						end else if (has_room) begin
							state_q <= ST_ACC;
						end
					end
				end
				ST_ACC: begin
					run_q   <= mul_p;
					state_q <= ST_LOAD;
				end
				ST_BRD: state_q <= ST_BM1;
				ST_BM1: state_q <= ST_BM2;
				ST_BM2: state_q <= ST_BM3;
				ST_BM3: begin
					if (idx_q == '0) begin
						state_q <= ST_ERD;
					end else begin
						idx_q   <= idx_q - CW'(1);
						state_q <= ST_BM1;
					end
				end
				ST_ERD: state_q <= ST_EFST;
				ST_EFST: begin
					out_valid_q <= 1'b1;
					idx_q       <= idx_nxt;
					state_q     <= ST_EOUT;
				end
				ST_EOUT: begin
					if (rsp_acc) begin
						if (out_q.last_result) begin
							out_valid_q <= 1'b0;
							count_q     <= '0;
							idx_q       <= '0;
							run_q       <= DW'(1);
							ovf_q       <= 1'b0;
							state_q     <= ST_LOAD;
						end else begin
							idx_q <= idx_nxt;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// result register and suffix product carry no reset
	always_ff @(posedge clk) begin
		if (state_q == ST_BRD) begin
			suffix_q <= DW'(1);
		end else if (state_q == ST_BM3) begin
			suffix_q <= mul_p;
		end
		if ((state_q == ST_EFST) ||
				((state_q == ST_EOUT) && rsp_acc && !out_q.last_result)) begin
			out_q.product     <= part_rd;
			out_q.last_result <= is_end;
			out_q.truncated   <= ovf_q;
		end
	end

endmodule

/* hw/rtl/pes_checker.sv */
// ----------------------------------------------------------------------------
// pes_checker: port-level checks for product_except_self_core
// Watches both channels and the run sequencing they show.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pes_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_stall,
	input pes_pkg::pes_req_t req,
	input logic              rsp_valid,
	input logic              rsp_stall,
	input pes_pkg::pes_rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("rsp item changed while stalled");

	a_no_load_during_emit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> req_stall)
		else $error("req accepted while results pending");

	a_last_starts_pass: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req.is_last |=> req_stall && !rsp_valid)
		else $error("last element did not start the pass");

	a_last_result_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_stall && rsp.last_result |=> !rsp_valid && !req_stall)
		else $error("run did not end after last result");

	a_results_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_stall && !rsp.last_result |=> rsp_valid)
		else $error("gap between results of one run");

endmodule

bind product_except_self_core pes_checker u_pes_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
